FILE: rtl/nssdp_pkg.sv
// shared types and constants for the subset structure search block
package nssdp_pkg;
   localparam int MaxNodes  = 8;
   localparam int ScoreBits = 32;
   localparam int NodeW     = 3;
   localparam int SetW      = MaxNodes;
   localparam int SumW      = ScoreBits + 8;
   localparam int AddrW     = NodeW + SetW;

   typedef enum logic [0:0] {
      FUNC_LOAD = 1'b0,
      FUNC_RUN  = 1'b1
   } func_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BP_START, ST_BP_RD_BEST, ST_BP_RD_SCORE, ST_BP_CMP, ST_BP_RD_PICK, ST_BP_FINAL,
      ST_SK_START, ST_SK_RD_BEST, ST_SK_RD_SCORE, ST_SK_ADD, ST_SK_WRITE,
      ST_OR_RD, ST_OR_USE,
      ST_PR_RD, ST_PR_USE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              we;
      logic [AddrW-1:0]  waddr;
      logic [SetW-1:0]   wdata;
      logic [AddrW-1:0]  raddr;
   } bp_port_type;
endpackage

FILE: rtl/nssdp_score_mem.sv
// local score memory, one write and one registered read port
module nssdp_score_mem (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [nssdp_pkg::AddrW-1:0]           waddr,
   input  logic [nssdp_pkg::ScoreBits-1:0]       wdata,
   input  logic [nssdp_pkg::AddrW-1:0]           raddr,
   output logic [nssdp_pkg::ScoreBits-1:0]       rdata
);
   import nssdp_pkg::*;
   logic [ScoreBits-1:0] mem [0:(1<<AddrW)-1];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

FILE: rtl/nssdp_best_mem.sv
// best parent set memory
module nssdp_best_mem (
   input  logic                          clock,
   input  nssdp_pkg::bp_port_type        port,
   output logic [nssdp_pkg::SetW-1:0]    rdata
);
   import nssdp_pkg::*;
   logic [SetW-1:0] mem [0:(1<<AddrW)-1];
   always_ff @(posedge clock) begin
      if (port.we) mem[port.waddr] <= port.wdata;
      rdata <= mem[port.raddr];
   end
endmodule

FILE: rtl/network_structure_subset_dp.sv
// top level: load, parent search, sink search and order recovery sequencer
//
//  channel | dir | handshake       | payload
//  req     | in  | tvalid/tready   | tdata {local_score, candidate_set, node_index}, tuser func
//  rsp     | out | tvalid/tready   | tdata {parent_set, result_node}, tlast last
//  csr     | in  | apb, pready=1   | node_count at address 0
//
// a load is written to the score memory as it is accepted; loads follow back to back
// parent pass per child, set: skip if it holds the child, else best, score, compare per member
// sink pass per subset: best, sum, score, add per member; order, parents: read, use per node
// reset is synchronous; no clearing pass, best and sum stores are rebuilt on every run
// results stall on rsp_tready; no input is taken during a run
module network_structure_subset_dp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // node_index[2:0], candidate_set[10:3], local_score[42:11]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result_node[2:0], parent_set[10:3]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import nssdp_pkg::*;

   localparam logic [1:0] RegNodeCount = 2'd0;

   state_type state_ff, state_in;
   logic [3:0] ncount_ff;
   logic [3:0] n_ff, n_in;              // effective node count
   logic [3:0] node_cursor_ff, node_cursor_in;
   logic [8:0] subset_cursor_ff, subset_cursor_in;
   logic [2:0] v_ff, v_in;              // child under test, or result node on output
   logic [3:0] i_ff, i_in;              // member loop
   logic [7:0] top_pick_ff, top_pick_in;
   logic [SumW-1:0] top_ff, top_in;
   logic [2:0] sink_ff, sink_in;
   logic       sink_set_ff, sink_set_in;
   logic [7:0] cand_ff, cand_in;
   logic [SumW-1:0] rest_sum_ff, rest_sum_in;
   logic [7:0] pattern_ff, pattern_in;
   logic [7:0] predecs_ff, predecs_in;
   logic [7:0] parents_ff [0:MaxNodes-1];
   logic [7:0] parents_in [0:MaxNodes-1];
   logic [2:0] order_ff [0:MaxNodes-1];
   logic [2:0] order_in [0:MaxNodes-1];
   logic [SumW-1:0] sum_mem [0:255];
   logic [2:0]      sinkm [0:255];
   logic [SumW-1:0] sum_rd;
   logic [2:0]      sink_rd;
   logic [7:0]      sm_raddr;
   logic            sm_we;
   logic [7:0]      sm_waddr;
   logic [SumW-1:0] sm_wsum;
   logic [2:0]      sm_wsink;

   logic            sc_we;
   logic [AddrW-1:0] sc_waddr, sc_raddr;
   logic [ScoreBits-1:0] sc_rd;
   bp_port_type     bp;
   logic [7:0]      bp_rd;

   logic [7:0] full, set_c, rest;
   logic       in_acc, cfg_wr;
   logic [SumW-1:0] sum_t, sc_ext;
   logic [SumW:0]   sum_w;

   assign set_c = subset_cursor_ff[7:0];
   assign full  = 8'((9'd1 << n_ff) - 9'd1);
   assign rest  = set_c & ~(8'd1 << i_ff[2:0]);
   assign in_acc = req_tvalid && req_tready;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegNodeCount) ? {28'd0, ncount_ff} : 32'd0;
   assign sc_ext = {8'd0, sc_rd};
   assign sum_w  = {1'b0, rest_sum_ff} + {1'b0, sc_ext};
   assign sum_t  = sum_w[SumW] ? {SumW{1'b1}} : sum_w[SumW-1:0];

   nssdp_score_mem u_score (.clock(clock), .we(sc_we), .waddr(sc_waddr),
      .wdata(req_tdata[42:11]), .raddr(sc_raddr), .rdata(sc_rd));
   nssdp_best_mem u_best (.clock(clock), .port(bp), .rdata(bp_rd));

   always_ff @(posedge clock) begin
      if (sm_we) begin
         sum_mem[sm_waddr] <= sm_wsum;
         sinkm[sm_waddr] <= sm_wsink;
      end
      sum_rd  <= sum_mem[sm_raddr];
      sink_rd <= sinkm[sm_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ncount_ff <= 4'd8;
         node_cursor_ff <= '0;
         subset_cursor_ff <= '0;
      end else begin
         state_ff <= state_in;
         node_cursor_ff <= node_cursor_in;
         subset_cursor_ff <= subset_cursor_in;
         if (cfg_wr && csr_paddr == RegNodeCount) ncount_ff <= csr_pwdata[3:0];
      end
      n_ff <= n_in; v_ff <= v_in; i_ff <= i_in; top_pick_ff <= top_pick_in;
      top_ff <= top_in; sink_ff <= sink_in; sink_set_ff <= sink_set_in;
      cand_ff <= cand_in; rest_sum_ff <= rest_sum_in; pattern_ff <= pattern_in;
      predecs_ff <= predecs_in;
      parents_ff <= parents_in;
      order_ff <= order_in;
   end

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; v_in = v_ff; i_in = i_ff; top_pick_in = top_pick_ff;
      top_in = top_ff; sink_in = sink_ff; sink_set_in = sink_set_ff;
      cand_in = cand_ff; rest_sum_in = rest_sum_ff; pattern_in = pattern_ff;
      predecs_in = predecs_ff; parents_in = parents_ff; order_in = order_ff;
      node_cursor_in = node_cursor_ff; subset_cursor_in = subset_cursor_ff;
      req_tready = 1'b0;
      sc_we = 1'b0;
      sc_waddr = {req_tdata[2:0], req_tdata[10:3]};
      sc_raddr = '0;
      bp = '0;
      sm_raddr = '0; sm_we = 1'b0; sm_waddr = set_c; sm_wsum = top_ff; sm_wsink = sink_ff;
      rsp_tvalid = 1'b0;
      rsp_tdata = {5'd0, parents_ff[v_ff], v_ff};
      rsp_tlast = ({1'b0, v_ff} == n_ff - 4'd1);
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (in_acc) begin
               if (req_tuser == FUNC_LOAD) begin
                  sc_we = 1'b1;
               end else if (ncount_ff != 4'd0) begin
                  n_in = (ncount_ff > 4'd8) ? 4'd8 : ncount_ff;
                  v_in = '0;
                  subset_cursor_in = '0;
                  state_in = ST_BP_START;
               end
            end
         end
         // parent search: per child v, per set c
         ST_BP_START: begin
            if (set_c[v_ff]) begin
               state_in = ST_BP_FINAL;  // skipped set, advance only
               top_pick_in = 8'hff;
            end else begin
               top_in = '0; top_pick_in = '0; i_in = '0;
               state_in = ST_BP_RD_BEST;
            end
         end
         ST_BP_RD_BEST: begin
            if (i_ff == n_ff) begin
               sc_raddr = {v_ff, set_c};
               state_in = ST_BP_RD_PICK;
            end else if (set_c[i_ff[2:0]]) begin
               bp.raddr = {v_ff, rest};
               state_in = ST_BP_RD_SCORE;
            end else begin
               i_in = i_ff + 4'd1;
            end
         end
         ST_BP_RD_SCORE: begin
            cand_in = bp_rd;
            sc_raddr = {v_ff, bp_rd};
            state_in = ST_BP_CMP;
         end
         ST_BP_CMP: begin
            if (sc_ext > top_ff) begin
               top_in = sc_ext; top_pick_in = cand_ff;
            end
            i_in = i_ff + 4'd1;
            state_in = ST_BP_RD_BEST;
         end
         ST_BP_RD_PICK: begin
            rest_sum_in = sc_ext;   // score(c)
            sc_raddr = {v_ff, top_pick_ff};
            state_in = ST_BP_FINAL;
         end
         ST_BP_FINAL: begin
            if (top_pick_ff != 8'hff || !set_c[v_ff]) begin
               bp.we = 1'b1;
               bp.waddr = {v_ff, set_c};
               bp.wdata = (rest_sum_ff > sc_ext) ? set_c : top_pick_ff;
            end
            if (set_c == full) begin
               subset_cursor_in = '0;
               if ({1'b0, v_ff} == n_ff - 4'd1) begin
                  subset_cursor_in = 9'd1;
                  sm_we = 1'b1; sm_waddr = '0; sm_wsum = '0; sm_wsink = '0;
                  state_in = ST_SK_START;
               end else begin
                  v_in = v_ff + 3'd1;
                  state_in = ST_BP_START;
               end
            end else begin
               subset_cursor_in = subset_cursor_ff + 9'd1;
               state_in = ST_BP_START;
            end
         end
         // sink search per subset
         ST_SK_START: begin
            top_in = '0; sink_set_in = 1'b0; i_in = '0;
            state_in = ST_SK_RD_BEST;
         end
         ST_SK_RD_BEST: begin
            if (i_ff == n_ff) begin
               state_in = ST_SK_WRITE;
            end else if (set_c[i_ff[2:0]]) begin
               bp.raddr = {i_ff[2:0], rest};
               sm_raddr = rest;
               if (!sink_set_ff) begin
                  sink_in = i_ff[2:0]; sink_set_in = 1'b1;
               end
               state_in = ST_SK_RD_SCORE;
            end else begin
               i_in = i_ff + 4'd1;
            end
         end
         ST_SK_RD_SCORE: begin
            rest_sum_in = sum_rd;
            sc_raddr = {i_ff[2:0], bp_rd};
            state_in = ST_SK_ADD;
         end
         ST_SK_ADD: begin
            if (sum_t > top_ff) begin
               top_in = sum_t; sink_in = i_ff[2:0];
            end
            i_in = i_ff + 4'd1;
            state_in = ST_SK_RD_BEST;
         end
         ST_SK_WRITE: begin
            sm_we = 1'b1;
            if (set_c == full) begin
               pattern_in = full; i_in = n_ff;
               state_in = ST_OR_RD;
            end else begin
               subset_cursor_in = subset_cursor_ff + 9'd1;
               state_in = ST_SK_START;
            end
         end
         // order recovery from the sink of each remaining pattern
         ST_OR_RD: begin
            sm_raddr = pattern_ff;
            state_in = ST_OR_USE;
         end
         ST_OR_USE: begin
            order_in[i_ff[2:0] - 3'd1] = sink_rd;
            pattern_in = pattern_ff & ~(8'd1 << sink_rd);
            i_in = i_ff - 4'd1;
            if (i_ff == 4'd1) begin
               predecs_in = '0;
               state_in = ST_PR_RD;
            end else begin
               state_in = ST_OR_RD;
            end
         end
         ST_PR_RD: begin
            bp.raddr = {order_ff[i_ff[2:0]], predecs_ff};
            state_in = ST_PR_USE;
         end
         ST_PR_USE: begin
            parents_in[order_ff[i_ff[2:0]]] = bp_rd;
            predecs_in = predecs_ff | (8'd1 << order_ff[i_ff[2:0]]);
            i_in = i_ff + 4'd1;
            if (i_ff + 4'd1 == n_ff) begin
               v_in = '0;
               node_cursor_in = n_ff;
               subset_cursor_in = 9'd1 << n_ff;
               state_in = ST_OUT;
            end else begin
               state_in = ST_PR_RD;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               v_in = v_ff + 3'd1;
               if (rsp_tlast) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic unused_ok;
   assign unused_ok = ^{req_tdata[47:43], csr_pwdata[31:4], node_cursor_ff,
                        subset_cursor_ff[8], FUNC_RUN};
endmodule

FILE: dv/testbench.sv
// self-checking testbench for the subset structure search block
`timescale 1ns / 100ps

module testbench;
   import nssdp_pkg::*;

   class parent_scoreboard;
      logic [ScoreBits-1:0] score_mem [MaxNodes][1 << MaxNodes];
      logic [SetW-1:0]      best_mem [MaxNodes][1 << MaxNodes];
      logic [SumW-1:0]      sum_mem [1 << MaxNodes];
      int                   sink_mem [1 << MaxNodes];
      logic [3:0]           node_count = 4'd8;
      logic [NodeW+SetW:0]  pending_q [$];
      int                   mismatches = 0;
      int                   results_seen = 0;
      int                   runs_done = 0;

      function void note_input(func_type func, logic [NodeW-1:0] node,
                               logic [SetW-1:0] cset, logic [ScoreBits-1:0] score);
         int n, full, pick, cand, rest, sink, pattern, s, v;
         int order [MaxNodes];
         logic [SetW-1:0] parents [MaxNodes];
         logic [SumW-1:0] top, a;
         logic [SumW:0]   t;
         logic [SetW-1:0] predecs;
         logic [ScoreBits-1:0] best_score;
         if (func == FUNC_LOAD) begin
            score_mem[node][cset] = score;
            return;
         end
         n = (node_count > MaxNodes) ? MaxNodes : node_count;
         if (n == 0) return;
         runs_done++;
         full = (1 << n) - 1;
         for (v = 0; v < n; v++) begin
            for (int c = 0; c <= full; c++) begin
               if (c[v]) continue;
               best_score = '0;
               pick = 0;
               for (int i = 0; i < n; i++) begin
                  if (c[i]) begin
                     cand = best_mem[v][c & ~(1 << i)];
                     if (score_mem[v][cand] > best_score) begin
                        best_score = score_mem[v][cand];
                        pick = cand;
                     end
                  end
               end
               best_mem[v][c] = (score_mem[v][c] > score_mem[v][pick]) ? c : pick;
            end
         end
         sum_mem[0] = '0;
         sink_mem[0] = 0;
         for (s = 1; s <= full; s++) begin
            top = '0;
            sink = MaxNodes;
            for (v = 0; v < n; v++) begin
               if (!s[v]) continue;
               if (sink == MaxNodes) sink = v;
               rest = s & ~(1 << v);
               a = sum_mem[rest];
               t = {1'b0, a} + {9'b0, score_mem[v][best_mem[v][rest]]};
               if (t[SumW]) t = {1'b0, {SumW{1'b1}}};
               if (t[SumW-1:0] > top) begin
                  top = t[SumW-1:0];
                  sink = v;
               end
            end
            sum_mem[s] = top;
            sink_mem[s] = sink;
         end
         pattern = full;
         for (int i = n - 1; i >= 0; i--) begin
            order[i] = sink_mem[pattern] % MaxNodes;
            pattern &= ~(1 << order[i]);
         end
         predecs = '0;
         for (int i = 0; i < n; i++) begin
            parents[order[i]] = best_mem[order[i]][predecs];
            predecs[order[i]] = 1'b1;
         end
         for (int i = 0; i < n; i++)
            pending_q.push_back({(i == n - 1), parents[i], i[NodeW-1:0]});
      endfunction

      function void check_result(logic [NodeW-1:0] node, logic [SetW-1:0] pset, logic last);
         logic [NodeW+SetW:0] want;
         results_seen++;
         if (pending_q.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: node %0d parents %h last %0d", node, pset, last);
            mismatches++;
            return;
         end
         want = pending_q.pop_front();
         if (want != {last, pset, node}) begin
            if (mismatches < 10)
               $display("mismatch: expected node %0d parents %h last %0d, got %0d %h %0d",
                        want[NodeW-1:0], want[NodeW+SetW-1:NodeW], want[NodeW+SetW],
                        node, pset, last);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // node_index[2:0], candidate_set[10:3], local_score[42:11]
   logic        req_tuser;    // func
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // result_node[2:0], parent_set[10:3]
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   parent_scoreboard sb = new();
   bit  loaded [MaxNodes][1 << MaxNodes];
   int  send_idle_pct = 10;
   int  recv_stall_pct = 52;
   int  hold_cycles = 0;
   bit  hold_done = 0;
   int  items_sent = 0;

   network_structure_subset_dp u_top (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver side: check each accepted transaction, then decide the next tready
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[2:0], rsp_tdata[10:3], rsp_tlast);
         // long hold while another run waits at the input
         if (!hold_done && rsp_tvalid && req_tvalid && items_sent > 150) begin
            hold_done = 1;
            hold_cycles = 3000;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(func_type func, logic [2:0] node, logic [7:0] cset,
                            logic [31:0] score);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func[0];
      req_tdata  <= {5'b0, score, cset, node};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(func, node, cset, score);
      if (func == FUNC_LOAD) loaded[node][cset] = 1;
      items_sent++;
   endtask

   function automatic logic [31:0] pick_score();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hffff_ffff;
         2: return $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   // every score a run of this size will read must have been written
   task automatic fill_scores(int n);
      for (int v = 0; v < n; v++)
         for (int c = 0; c < (1 << n); c++)
            if (!c[v] && !loaded[v][c])
               send_item(FUNC_LOAD, 3'(v), 8'(c), pick_score());
   endtask

   task automatic write_node_count(logic [3:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 2'd0;
      csr_pwdata  <= {28'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.node_count = value;
   endtask

   initial begin
      int n, eff, nloads, v;
      int phase_n [24] = '{1, 2, 0, 3, 6, 5, 1, 4, 2, 5, 3, 1, 6, 2, 4, 3,
                           5, 1, 2, 6, 3, 4, 4, 2};
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < 24; ph++) begin
         if (ph == 8) begin
            send_idle_pct = 52;
            recv_stall_pct = 10;
         end else if (ph == 16) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         n = phase_n[ph];
         eff = (n > MaxNodes) ? MaxNodes : n;
         write_node_count(4'(n));
         nloads = (ph < 6) ? 3 : $urandom_range(12, 2);
         for (int k = 0; k < nloads; k++) begin
            // mostly scores the coming run reads, some anywhere in the store
            if ($urandom_range(3) == 0 || eff == 0) begin
               send_item(FUNC_LOAD, 3'($urandom_range(7)), 8'($urandom_range(255)),
                         pick_score());
            end else begin
               v = $urandom_range(eff - 1);
               send_item(FUNC_LOAD, 3'(v),
                         8'($urandom_range((1 << eff) - 1) & ~(1 << v)), pick_score());
            end
         end
         fill_scores(eff);
         send_item(FUNC_RUN, 3'($urandom_range(7)), 8'($urandom_range(255)), $urandom);
         if (ph % 5 == 1)
            send_item(FUNC_RUN, 3'($urandom_range(7)), 8'($urandom_range(255)), $urandom);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);

      $display("sent %0d transactions over 24 node count settings, %0d searches",
               items_sent, sb.runs_done);
      $display("checked %0d parent set results, %0d mismatches",
               sb.results_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
